[rtl/core/rpn_pkg.sv]
// shared types, codes and constants of the rpn stack calculator
package rpn_pkg;

   localparam int STACK_DEPTH_DEF = 128;

   localparam logic [3:0] OP_PUSH  = 4'd0;
   localparam logic [3:0] OP_ADD   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_SUB   = 4'd3;
   localparam logic [3:0] OP_DIV   = 4'd4;
   localparam logic [3:0] OP_REM   = 4'd5;
   localparam logic [3:0] OP_PEEK  = 4'd6;
   localparam logic [3:0] OP_SWAP  = 4'd7;
   localparam logic [3:0] OP_DUP   = 4'd8;
   localparam logic [3:0] OP_CLEAR = 4'd9;
   localparam logic [3:0] OP_PRINT = 4'd10;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_FULL  = 2'd1;
   localparam logic [1:0] STS_EMPTY = 2'd2;
   localparam logic [1:0] STS_ZDIV  = 2'd3;

   localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   localparam int DIV_STEPS = 48;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] operand_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] shown_value;
      logic               shown_valid;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_POP_B, ST_LAT_B, ST_POP_A, ST_LAT_A, ST_ALU, ST_MUL,
      ST_DIV, ST_DIV_FIN, ST_PUSH1, ST_PUSH2, ST_CLEAR, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_REM
   } alu_op_type;

   typedef enum logic [1:0] {
      PS_OPERAND, PS_RESULT, PS_B, PS_A
   } push_sel_type;

   typedef struct packed {
      logic         load;
      logic         pop;
      logic         lat_b;
      logic         lat_a;
      logic         alu;
      alu_op_type   alu_op;
      logic         mul_fin;
      logic         div_step;
      logic         div_fin;
      logic         push;
      push_sel_type push_sel;
      logic         clear;
      logic         err_zdiv;
      logic         out_load;
      logic         show;
   } cmd_type;

   typedef struct packed {
      logic b_zero;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

[rtl/core/rpn_ctrl.sv]
// command sequencer of the rpn stack calculator
module rpn_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [3:0]       req_opcode,
   input  rpn_pkg::sts_type sts,
   output rpn_pkg::cmd_type cmd
);
   import rpn_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic [3:0] op_cur;

   assign op_cur = (state_ff == ST_IDLE) ? req_opcode : op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_PUSH;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               case (req_opcode) inside
                  OP_PUSH:  state_in = ST_PUSH1;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_REM,
                  OP_PEEK, OP_SWAP, OP_DUP, OP_PRINT: state_in = ST_POP_B;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_POP_B: state_in = ST_LAT_B;
         ST_LAT_B: begin
            case (op_ff) inside
               OP_PEEK, OP_DUP: state_in = ST_PUSH1;
               OP_PRINT:        state_in = ST_DONE;
               OP_DIV, OP_REM:  state_in = sts.b_zero ? ST_DONE : ST_POP_A;
               default:         state_in = ST_POP_A;
            endcase
         end
         ST_POP_A: state_in = ST_LAT_A;
         ST_LAT_A: state_in = (op_ff == OP_SWAP) ? ST_PUSH1 : ST_ALU;
         ST_ALU: begin
            case (op_ff) inside
               OP_MUL:         state_in = ST_MUL;
               OP_DIV, OP_REM: state_in = ST_DIV;
               default:        state_in = ST_PUSH1;
            endcase
         end
         ST_MUL:     state_in = ST_PUSH1;
         ST_DIV:     state_in = sts.div_last ? ST_DIV_FIN : ST_DIV;
         ST_DIV_FIN: state_in = ST_PUSH1;
         ST_PUSH1: begin
            if (op_ff == OP_SWAP || op_ff == OP_DUP) state_in = ST_PUSH2;
            else state_in = ST_DONE;
         end
         ST_PUSH2: state_in = ST_DONE;
         ST_CLEAR: state_in = ST_DONE;
         ST_DONE:  state_in = sts.out_free ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (op_cur)
         OP_SUB:  cmd.alu_op = ALU_SUB;
         OP_MUL:  cmd.alu_op = ALU_MUL;
         OP_DIV:  cmd.alu_op = ALU_DIV;
         OP_REM:  cmd.alu_op = ALU_REM;
         default: cmd.alu_op = ALU_ADD;
      endcase
      cmd.show = (op_cur == OP_PEEK) || (op_cur == OP_PRINT);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_POP_B, ST_POP_A: cmd.pop = 1'b1;
         ST_LAT_B: begin
            cmd.lat_b    = 1'b1;
            cmd.err_zdiv = (op_ff == OP_DIV || op_ff == OP_REM) && sts.b_zero;
         end
         ST_LAT_A:   cmd.lat_a    = 1'b1;
         ST_ALU:     cmd.alu      = 1'b1;
         ST_MUL:     cmd.mul_fin  = 1'b1;
         ST_DIV:     cmd.div_step = 1'b1;
         ST_DIV_FIN: cmd.div_fin  = 1'b1;
         ST_PUSH1: begin
            cmd.push = 1'b1;
            case (op_ff) inside
               OP_PUSH:                  cmd.push_sel = PS_OPERAND;
               OP_PEEK, OP_DUP, OP_SWAP: cmd.push_sel = PS_B;
               default:                  cmd.push_sel = PS_RESULT;
            endcase
         end
         ST_PUSH2: begin
            cmd.push     = 1'b1;
            cmd.push_sel = (op_ff == OP_SWAP) ? PS_A : PS_B;
         end
         ST_CLEAR: cmd.clear    = 1'b1;
         ST_DONE:  cmd.out_load = sts.out_free;
         default:  cmd.load     = 1'b0;
      endcase
   end

endmodule

[rtl/core/rpn_dp.sv]
// stack memory, arithmetic units and result register of the rpn stack calculator
module rpn_dp #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      operand_value,
   input  rpn_pkg::cmd_type cmd,
   output rpn_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rpn_pkg::rsp_type rsp_data
);
   import rpn_pkg::*;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
   localparam int DCNT_W = $clog2(DIV_STEPS);

   logic [31:0] mem [STACK_DEPTH];

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_dec;
   logic [31:0]       rd_data_ff;
   logic              pop_empty_ff;
   logic [31:0]       operand_ff, a_ff, b_ff, res_ff, push_val, pop_val;
   logic [1:0]        err_ff;
   logic              rem_mode_ff;
   logic signed [63:0] prod_ff;
   logic [32:0]       sum;
   logic [47:0]       dvd_ff;
   logic [31:0]       rem_ff, dvs_ff, a_mag, b_mag;
   logic [32:0]       rem_sh;
   logic              ge;
   logic [DCNT_W-1:0] dcnt_ff;
   logic              full;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic signed [63:0] shifted;
   logic              neg;

   assign count_dec = count_ff - CNT_W'(1);
   assign full      = (count_ff >= DEPTH_C);
   assign pop_val   = pop_empty_ff ? 32'd0 : rd_data_ff;
   assign a_mag     = a_ff[31] ? (32'd0 - a_ff) : a_ff;
   assign b_mag     = b_ff[31] ? (32'd0 - b_ff) : b_ff;
   assign rem_sh    = {rem_ff, dvd_ff[47]};
   assign ge        = (rem_sh >= {1'b0, dvs_ff});
   assign shifted   = prod_ff >>> 16;
   assign neg       = a_ff[31] ^ b_ff[31];
   assign sum       = (cmd.alu_op == ALU_SUB) ? ({a_ff[31], a_ff} - {b_ff[31], b_ff})
                                              : ({a_ff[31], a_ff} + {b_ff[31], b_ff});

   assign sts.b_zero   = (pop_val == 32'd0);
   assign sts.div_last = (dcnt_ff == DCNT_W'(DIV_STEPS - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cmd.push_sel)
         PS_OPERAND: push_val = operand_ff;
         PS_RESULT:  push_val = res_ff;
         PS_B:       push_val = b_ff;
         default:    push_val = a_ff;
      endcase
   end

   // stack memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.push && !full) mem[count_ff[ADDR_W-1:0]] <= push_val;
      if (cmd.pop) rd_data_ff <= mem[count_dec[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= STS_OK;
         pop_empty_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         if (cmd.load) err_ff <= STS_OK;
         if (cmd.pop) begin
            pop_empty_ff <= (count_ff == '0);
            if (count_ff != '0) count_ff <= count_dec;
            else if (err_ff == STS_OK) err_ff <= STS_EMPTY;
         end
         if (cmd.err_zdiv && err_ff == STS_OK) err_ff <= STS_ZDIV;
         if (cmd.push) begin
            if (!full) count_ff <= count_ff + CNT_W'(1);
            else if (err_ff == STS_OK) err_ff <= STS_FULL;
         end
         if (cmd.clear) count_ff <= '0;
         if (cmd.alu) dcnt_ff <= '0;
         else if (cmd.div_step) dcnt_ff <= dcnt_ff + DCNT_W'(1);
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) operand_ff <= operand_value;
      if (cmd.lat_b) b_ff <= pop_val;
      if (cmd.lat_a) a_ff <= pop_val;
      if (cmd.alu) begin
         rem_mode_ff <= (cmd.alu_op == ALU_REM);
         prod_ff     <= $signed(a_ff) * $signed(b_ff);
         dvs_ff      <= b_mag;
         rem_ff      <= '0;
         dvd_ff      <= (cmd.alu_op == ALU_DIV) ? {a_mag, 16'd0} : {16'd0, a_mag};
         if (sum[32] != sum[31]) res_ff <= sum[32] ? Q_MIN : Q_MAX;
         else res_ff <= sum[31:0];
      end
      if (cmd.mul_fin) begin
         if (prod_ff[63:47] != {17{prod_ff[63]}}) res_ff <= prod_ff[63] ? Q_MIN : Q_MAX;
         else res_ff <= shifted[31:0];
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
         dvd_ff <= {dvd_ff[46:0], ge};
      end
      if (cmd.div_fin) begin
         if (rem_mode_ff) res_ff <= a_ff[31] ? (32'd0 - rem_ff) : rem_ff;
         else if (neg) res_ff <= (dvd_ff > 48'h0000_8000_0000) ? Q_MIN
                                                               : 32'd0 - dvd_ff[31:0];
         else res_ff <= (dvd_ff >= 48'h0000_8000_0000) ? Q_MAX : dvd_ff[31:0];
      end
      if (cmd.out_load) begin
         rsp_ff.shown_value <= cmd.show ? b_ff : 32'd0;
         rsp_ff.shown_valid <= cmd.show;
         rsp_ff.status      <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/rpn_stack_calculator_top.sv]
// top level of the rpn stack calculator: sequencer plus datapath
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_data  (opcode, operand_value)
//  rsp      out        rsp_valid / rsp_ready  rsp_data  (shown_value, shown_valid, status)
//
// one transaction at a time; push and clear go to a push or clear step, unknown opcodes
// straight to the result hand-off, pop based commands first pop their operands (a zero
// divisor stops there); divide and remainder run the 48-step restoring divider
// reset clears the stack count, the sequencer and the result valid; entries stay as they are
// the result waits in an output register, so a stalled rsp side holds the sequencer only
// at its final step; a new transaction is taken as soon as the result is handed over
module rpn_stack_calculator_top #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rpn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rpn_pkg::rsp_type rsp_data
);
   import rpn_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: walks pops, arithmetic, pushes and result hand-off
   rpn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: stack memory, count, adder, multiplier, divider, result register
   rpn_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .operand_value (req_data.operand_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

[tb/testbench.sv]
// self-checking testbench of the rpn stack calculator
`timescale 1ns / 100ps

module testbench;
   import rpn_pkg::*;

   localparam int DEPTH        = STACK_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1950;
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_REPORTS  = 30;
   localparam logic [3:0] OP_BAD_LO = 4'd11;
   localparam logic [3:0] OP_BAD_HI = 4'd15;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rpn_stack_calculator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // calculator model: its own stack copy, updated per accepted transaction
   // ------------------------------------------------------------------
   logic signed [31:0] calc_stack [DEPTH];
   int                 calc_depth;
   logic [1:0]         calc_status;

   // only the first error of a command is kept
   function automatic void note_error(logic [1:0] code);
      if (calc_status == STS_OK) calc_status = code;
   endfunction

   function automatic logic signed [31:0] saturate(longint v);
      if (v > longint'(32'sh7fff_ffff)) return Q_MAX;
      if (v < -longint'(64'sh8000_0000)) return Q_MIN;
      return v[31:0];
   endfunction

   function automatic void stack_push(logic signed [31:0] v);
      if (calc_depth < DEPTH) begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end else begin
         note_error(STS_FULL);
      end
   endfunction

   // empty pop gives zero and the command carries on with it
   function automatic logic signed [31:0] stack_pop();
      if (calc_depth > 0) begin
         calc_depth--;
         return calc_stack[calc_depth];
      end
      note_error(STS_EMPTY);
      return '0;
   endfunction

   function automatic rsp_type calc_command(req_type r);
      rsp_type            res;
      logic signed [31:0] a, b;
      longint             prod;
      res         = '0;
      calc_status = STS_OK;
      case (r.opcode)
         OP_PUSH: stack_push(r.operand_value);
         OP_ADD, OP_SUB, OP_MUL: begin
            b = stack_pop();
            a = stack_pop();
            if (r.opcode == OP_ADD)
               stack_push(saturate(longint'(a) + longint'(b)));
            else if (r.opcode == OP_SUB)
               stack_push(saturate(longint'(a) - longint'(b)));
            else begin
               // arithmetic shift of the signed product rounds toward minus infinity
               prod = longint'(a) * longint'(b);
               stack_push(saturate(prod >>> 16));
            end
         end
         OP_DIV, OP_REM: begin
            b = stack_pop();
            if (b != 0) begin
               a = stack_pop();
               if (r.opcode == OP_DIV)
                  stack_push(saturate((longint'(a) * 65536) / longint'(b)));
               else begin
                  prod = longint'(a) % longint'(b);
                  stack_push(prod[31:0]);
               end
            end else begin
               // divisor consumed, dividend left in place
               note_error(STS_ZDIV);
            end
         end
         OP_PEEK: begin
            a = stack_pop();
            res.shown_value = a;
            res.shown_valid = 1'b1;
            stack_push(a);
         end
         OP_SWAP: begin
            b = stack_pop();
            a = stack_pop();
            stack_push(b);
            stack_push(a);
         end
         OP_DUP: begin
            a = stack_pop();
            stack_push(a);
            stack_push(a);
         end
         OP_CLEAR: calc_depth = 0;
         OP_PRINT: begin
            res.shown_value = stack_pop();
            res.shown_valid = 1'b1;
         end
         default: ;
      endcase
      res.status = calc_status;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // directed table: typed expectations only where obvious at a glance
   // ------------------------------------------------------------------
   typedef struct packed {
      req_type cmd;
      logic    fixed;
      rsp_type want;
   } row_type;

   function automatic row_type row(logic [3:0] op, logic [31:0] v, logic fixed = 1'b0,
                                   logic [31:0] sv = '0, logic vld = 1'b0,
                                   logic [1:0] st = STS_OK);
      row_type t;
      t.cmd.opcode        = op;
      t.cmd.operand_value = v;
      t.fixed             = fixed;
      t.want.shown_value  = sv;
      t.want.shown_valid  = vld;
      t.want.status       = st;
      return t;
   endfunction

   row_type directed_rows [$];

   initial begin
      // empty-stack behavior straight after reset
      directed_rows.push_back(row(OP_PRINT, 0, 1, 0, 1, STS_EMPTY));
      directed_rows.push_back(row(OP_PEEK, 0, 1, 0, 1, STS_EMPTY));   // pushes a zero
      directed_rows.push_back(row(OP_CLEAR, 0, 1, 0, 0, STS_OK));
      directed_rows.push_back(row(OP_ADD, 0, 1, 0, 0, STS_EMPTY));
      directed_rows.push_back(row(OP_CLEAR, 0, 1, 0, 0, STS_OK));
      // positive saturation of add
      directed_rows.push_back(row(OP_PUSH, Q_MAX, 1, 0, 0, STS_OK));
      directed_rows.push_back(row(OP_PUSH, Q_MAX, 1, 0, 0, STS_OK));
      directed_rows.push_back(row(OP_ADD, 0));
      directed_rows.push_back(row(OP_PRINT, 0, 1, Q_MAX, 1, STS_OK));
      // negative saturation of sub
      directed_rows.push_back(row(OP_PUSH, Q_MIN, 1, 0, 0, STS_OK));
      directed_rows.push_back(row(OP_PUSH, 32'h0001_0000, 1, 0, 0, STS_OK));
      directed_rows.push_back(row(OP_SUB, 0));
      directed_rows.push_back(row(OP_PRINT, 0, 1, Q_MIN, 1, STS_OK));
      // zero divisor keeps the dividend
      directed_rows.push_back(row(OP_PUSH, 32'h0005_0000, 1, 0, 0, STS_OK));
      directed_rows.push_back(row(OP_PUSH, 0, 1, 0, 0, STS_OK));
      directed_rows.push_back(row(OP_DIV, 0, 1, 0, 0, STS_ZDIV));
      directed_rows.push_back(row(OP_PUSH, 0));
      directed_rows.push_back(row(OP_REM, 0, 1, 0, 0, STS_ZDIV));
      directed_rows.push_back(row(OP_PRINT, 0, 1, 32'h0005_0000, 1, STS_OK));
      // most negative over minus one, remainder sign, big product
      directed_rows.push_back(row(OP_PUSH, Q_MIN));
      directed_rows.push_back(row(OP_PUSH, 32'hffff_0000));
      directed_rows.push_back(row(OP_DIV, 0));
      directed_rows.push_back(row(OP_PUSH, 32'hfff9_0000));
      directed_rows.push_back(row(OP_PUSH, 32'h0002_0000));
      directed_rows.push_back(row(OP_REM, 0));
      directed_rows.push_back(row(OP_DUP, 0));
      directed_rows.push_back(row(OP_MUL, 0));
      directed_rows.push_back(row(OP_CLEAR, 0));
      // swap with a single entry, then unknown opcodes do nothing
      directed_rows.push_back(row(OP_PUSH, 32'h0000_0003));
      directed_rows.push_back(row(OP_SWAP, 0));
      directed_rows.push_back(row(OP_PEEK, 0));
      directed_rows.push_back(row(OP_BAD_LO, 32'hdead_beef, 1, 0, 0, STS_OK));
      directed_rows.push_back(row(OP_BAD_HI, 32'h1234_5678, 1, 0, 0, STS_OK));
   end

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------
   rsp_type pending_results [$];
   logic    cur_fixed;
   rsp_type cur_want;
   int      sent_count;
   int      random_sent;
   int      fill_runs;
   int      burst_left;
   logic    sender_done;

   // operand mix: full range, small numbers, extremes and zero
   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       return 0;
         1:       return Q_MAX;
         2:       return Q_MIN;
         3, 4:    return $urandom;
         default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
   endfunction

   // drive one transaction and hold it until accepted
   task automatic send_cmd(req_type c, logic fixed = 1'b0, rsp_type want = '0);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= c;
      cur_fixed  = fixed;
      cur_want   = want;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      // bursts of random length with random gaps in between
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
         repeat ($urandom_range(1, 8)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
   endtask

   task automatic send_op(logic [3:0] op, logic [31:0] v = '0);
      req_type c;
      c.opcode        = op;
      c.operand_value = v;
      send_cmd(c);
      random_sent++;
   endtask

   function automatic logic [3:0] pick_binary();
      logic [3:0] ops [5] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM};
      return ops[$urandom_range(0, 4)];
   endfunction

   task automatic drain_wait();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
   endtask

   initial begin
      int n;
      int sel;
      req_valid   = 1'b0;
      req_data    = '0;
      cur_fixed   = 1'b0;
      cur_want    = '0;
      sent_count  = 0;
      random_sent = 0;
      fill_runs   = 0;
      burst_left  = 0;
      sender_done = 1'b0;
      reset       = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_cmd(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].want);
      // sender pause: every result of the directed part must come back first
      drain_wait();
      send_op(OP_CLEAR);

      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent > RANDOM_ITEMS / 2 && random_sent < RANDOM_ITEMS / 2 + 20)
            drain_wait();
         sel = $urandom_range(0, 99);
         if (sel < 3) begin
            // fill the stack past its depth, then unwind a bit
            fill_runs++;
            send_op(OP_CLEAR);
            repeat (DEPTH + $urandom_range(1, 4)) send_op(OP_PUSH, pick_value());
            send_op(OP_DUP);
            send_op(OP_PEEK);
            repeat ($urandom_range(2, 6)) send_op(pick_binary());
            send_op(OP_PRINT);
            send_op(OP_CLEAR);
         end else if (sel < 85) begin
            // well-formed expression with random content
            n = $urandom_range(1, 4);
            repeat (n) send_op(OP_PUSH, pick_value());
            repeat (n - 1) begin
               case ($urandom_range(0, 9))
                  0:       send_op(OP_SWAP);
                  1:       send_op(OP_DUP);
                  2:       send_op(OP_PEEK);
                  default: ;
               endcase
               send_op(pick_binary());
            end
            if ($urandom_range(0, 2) != 0) send_op(OP_PRINT);
         end else begin
            // noise: any opcode, unknown ones included
            send_op(4'($urandom_range(0, 15)), $urandom);
         end
      end

      @(negedge clock);
      req_valid   <= 1'b0;
      sender_done  = 1'b1;
   end

   // ------------------------------------------------------------------
   // receiver: own stall pattern, one long hold-off so the block backs up
   // ------------------------------------------------------------------
   initial begin
      int mode;
      int cyc;
      rsp_ready = 1'b0;
      cyc       = 0;
      mode      = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == 3000) begin
            // long hold-off while the sender keeps offering
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (cyc % 200 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= $urandom_range(0, 1);
            2:       rsp_ready <= $urandom_range(0, 4) == 0;
            default: rsp_ready <= (cyc % 7) < 4;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // monitor, checker and watchdog, all sampled at the rising edge
   // ------------------------------------------------------------------
   int error_count;
   int checked_count;
   int shown_count;
   int full_seen;
   int empty_seen;
   int zdiv_seen;
   int idle_cycles;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch on result %0d: %s got %h expected %h",
                  checked_count, what, got, want);
   endtask

   initial begin
      calc_depth    = 0;
      calc_status   = STS_OK;
      error_count   = 0;
      checked_count = 0;
      shown_count   = 0;
      full_seen     = 0;
      empty_seen    = 0;
      zdiv_seen     = 0;
      idle_cycles   = 0;
   end

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type want;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            idle_cycles = 0;
            // model always advances; fixed rows override the expectation
            predicted = calc_command(req_data);
            pending_results.push_back(cur_fixed ? cur_want : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_data.shown_value, 32'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.shown_value !== want.shown_value)
                  report_mismatch("shown_value", rsp_data.shown_value, want.shown_value);
               if (rsp_data.shown_valid !== want.shown_valid)
                  report_mismatch("shown_valid", 32'(rsp_data.shown_valid),
                                  32'(want.shown_valid));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (want.shown_valid) shown_count++;
               if (want.status == STS_FULL) full_seen++;
               if (want.status == STS_EMPTY) empty_seen++;
               if (want.status == STS_ZDIV) zdiv_seen++;
            end
            checked_count++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // end of run: drain, settle, then verdict
   initial begin
      wait (sender_done);
      wait (pending_results.size() == 0);
      repeat (100) @(posedge clock);
      if (pending_results.size() != 0) error_count++;
      $display("run covered %0d commands, %0d results checked, %0d shown values",
               sent_count, checked_count, shown_count);
      $display("errors hit: %0d full, %0d empty, %0d zero divisor; %0d stack fills",
               full_seen, empty_seen, zdiv_seen, fill_runs);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
